// ===== rtl/graph_cycle_detect_dfs_defines.svh =====
// Assertion helpers for the RTL (included by gcdfs_seq)
`ifndef GRAPH_CYCLE_DETECT_DFS_DEFINES_SVH
`define GRAPH_CYCLE_DETECT_DFS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define GCDFS_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define GCDFS_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gcdfs_pkg.sv =====
package gcdfs_pkg;

  // Sizing
  localparam int MAX_NODES   = 64;
  localparam int MAX_ENTRIES = 256;

  localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PTR_W   = ENTRY_W + 1;              // entry index plus nil flag
  localparam int PAR_W   = NODE_W + 1;               // node plus no-parent flag
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);  // fill count 0..MAX_ENTRIES
  localparam int DEPTH_W = $clog2(MAX_NODES + 1);    // scan index / stack pointer

  // Fixed field widths of the stream words
  localparam int ACT_W   = 2;
  localparam int FNODE_W = 6;
  localparam int NCNT_W  = 7;
  localparam int STAT_W  = 3;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [PAR_W-1:0]   par_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  localparam ptr_t PTR_NIL   = ptr_t'(1) << ENTRY_W;
  localparam par_t NO_PARENT = par_t'(1) << NODE_W;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Result codes
  localparam logic [STAT_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_CYCLE = 3'd2;
  localparam logic [STAT_W-1:0] ST_CYCLE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;

  // One input word
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [FNODE_W-1:0] node_from;
    logic [FNODE_W-1:0] node_to;
    logic               directed;
  } item_t;

  // One walk stack frame
  typedef struct packed {
    node_t node;
    ptr_t  cur;
    par_t  par;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

endpackage

// ===== rtl/gcdfs_ram.sv =====
module gcdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gcdfs_seq.sv =====
`include "graph_cycle_detect_dfs_defines.svh"

module gcdfs_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gcdfs_pkg::item_t                  in_item,
  input  logic [gcdfs_pkg::NCNT_W-1:0]      node_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gcdfs_pkg::STAT_W-1:0]      out_status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_ADD_LINK,
    S_SCAN,
    S_W_HEAD,
    S_W_EXAM,
    S_W_EDGE,
    S_W_POP,
    S_W_POPLD,
    S_RESULT
  } state_t;

  state_t state;

  // Edge loading
  gcdfs_pkg::node_t  a_from;
  gcdfs_pkg::node_t  a_to;
  logic              a_dir;
  logic              a_second;
  gcdfs_pkg::entry_t a_entry;
  gcdfs_pkg::entry_t link_at;

  // Graph bookkeeping
  logic [gcdfs_pkg::MAX_NODES-1:0] list_valid;
  gcdfs_pkg::cnt_t                 used;

  // Walk
  logic [gcdfs_pkg::MAX_NODES-1:0] visited;
  gcdfs_pkg::depth_t               scan_i;
  gcdfs_pkg::depth_t               sp;
  gcdfs_pkg::node_t                t_node;
  gcdfs_pkg::ptr_t                 t_cur;
  gcdfs_pkg::par_t                 t_par;
  logic                            head_hit;
  logic [gcdfs_pkg::STAT_W-1:0]    res_status;

  // Memory ports
  logic              head_we, head_re, tail_we, tail_re;
  gcdfs_pkg::node_t  head_ra, tail_ra;
  gcdfs_pkg::entry_t head_rd, tail_rd;
  logic              tgt_we, nxt_we, ent_re;
  gcdfs_pkg::entry_t tgt_wa, nxt_wa, ent_ra;
  gcdfs_pkg::node_t  tgt_rd;
  gcdfs_pkg::ptr_t   nxt_wd, nxt_rd;
  logic              stk_we, stk_re;
  gcdfs_pkg::node_t  stk_wa, stk_ra;
  gcdfs_pkg::frame_t stk_wd, stk_rd;

  // Decode helpers
  gcdfs_pkg::entry_t e_now;
  gcdfs_pkg::depth_t n_lim;
  gcdfs_pkg::node_t  scan_node;
  logic              nodes_ok;
  logic              room_ok;
  logic              scan_done;
  logic              scan_start;
  logic              push;
  logic              add_done;

  assign in_ready  = (state == S_IDLE);
  assign e_now     = used[gcdfs_pkg::ENTRY_W-1:0];
  assign scan_node = scan_i[gcdfs_pkg::NODE_W-1:0];

  always_comb begin
    nodes_ok = (32'(in_item.node_from) < gcdfs_pkg::MAX_NODES) &&
               (32'(in_item.node_to) < gcdfs_pkg::MAX_NODES);
    if (in_item.directed) begin
      room_ok = (32'(used) < gcdfs_pkg::MAX_ENTRIES);
    end else begin
      room_ok = (32'(used) + 2 <= gcdfs_pkg::MAX_ENTRIES);
    end
    if (32'(node_count) > gcdfs_pkg::MAX_NODES) begin
      n_lim = gcdfs_pkg::DEPTH_W'(gcdfs_pkg::MAX_NODES);
    end else begin
      n_lim = gcdfs_pkg::DEPTH_W'(node_count);
    end
    scan_done  = (scan_i >= n_lim);
    scan_start = (state == S_SCAN) && !scan_done && !visited[scan_node];
    push       = (state == S_W_EDGE) && !visited[tgt_rd];
    add_done   = a_dir || a_second;
  end

  // Memory control
  always_comb begin
    tail_re = (state == S_ADD_RD);
    tail_ra = a_from;
    tail_we = (state == S_ADD_WR);
    head_we = (state == S_ADD_WR) && !list_valid[a_from];

    tgt_we  = (state == S_ADD_WR);
    tgt_wa  = e_now;
    nxt_we  = (state == S_ADD_WR) || (state == S_ADD_LINK);
    if (state == S_ADD_LINK) begin
      nxt_wa = link_at;
      nxt_wd = {1'b0, a_entry};
    end else begin
      nxt_wa = e_now;
      nxt_wd = gcdfs_pkg::PTR_NIL;
    end

    ent_re = (state == S_W_EXAM) && !t_cur[gcdfs_pkg::ENTRY_W];
    ent_ra = t_cur[gcdfs_pkg::ENTRY_W-1:0];

    head_re = scan_start || push;
    head_ra = push ? tgt_rd : scan_node;

    stk_we = push;
    stk_wa = sp[gcdfs_pkg::NODE_W-1:0];
    stk_wd = '{node: t_node, cur: nxt_rd, par: t_par};
    stk_re = (state == S_W_POP) && (sp != '0);
    stk_ra = gcdfs_pkg::NODE_W'(sp - 1'b1);
  end

  // Adjacency list heads and tails
  gcdfs_ram #(.WIDTH(gcdfs_pkg::ENTRY_W), .DEPTH(gcdfs_pkg::MAX_NODES)) u_head (
    .clk(clk), .we(head_we), .waddr(a_from), .wdata(e_now),
    .re(head_re), .raddr(head_ra), .rdata(head_rd)
  );

  gcdfs_ram #(.WIDTH(gcdfs_pkg::ENTRY_W), .DEPTH(gcdfs_pkg::MAX_NODES)) u_tail (
    .clk(clk), .we(tail_we), .waddr(a_from), .wdata(e_now),
    .re(tail_re), .raddr(tail_ra), .rdata(tail_rd)
  );

  // Entry pool: target node and next link
  gcdfs_ram #(.WIDTH(gcdfs_pkg::NODE_W), .DEPTH(gcdfs_pkg::MAX_ENTRIES)) u_target (
    .clk(clk), .we(tgt_we), .waddr(tgt_wa), .wdata(a_to),
    .re(ent_re), .raddr(ent_ra), .rdata(tgt_rd)
  );

  gcdfs_ram #(.WIDTH(gcdfs_pkg::PTR_W), .DEPTH(gcdfs_pkg::MAX_ENTRIES)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
    .re(ent_re), .raddr(ent_ra), .rdata(nxt_rd)
  );

  // Walk stack, frames below the top one
  gcdfs_ram #(.WIDTH(gcdfs_pkg::FRAME_W), .DEPTH(gcdfs_pkg::MAX_NODES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .re(stk_re), .raddr(stk_ra), .rdata(stk_rd)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      list_valid <= '0;
      visited    <= '0;
      used       <= '0;
    end else begin
      // Word taken; S_RESULT refills the register itself
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      if (head_re) begin
        head_hit <= list_valid[head_ra];
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_from   <= gcdfs_pkg::node_t'(in_item.node_from);
            a_to     <= gcdfs_pkg::node_t'(in_item.node_to);
            a_dir    <= in_item.directed;
            a_second <= 1'b0;
            case (in_item.action)
              gcdfs_pkg::ACT_ADD: begin
                if (nodes_ok && room_ok) begin
                  state <= S_ADD_RD;
                end else begin
                  res_status <= gcdfs_pkg::ST_DROPPED;
                  state      <= S_RESULT;
                end
              end
              gcdfs_pkg::ACT_RUN: begin
                visited <= '0;
                scan_i  <= '0;
                state   <= S_SCAN;
              end
              gcdfs_pkg::ACT_CLEAR: begin
                list_valid <= '0;
                used       <= '0;
                res_status <= gcdfs_pkg::ST_CLEARED;
                state      <= S_RESULT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_ADD_RD: begin
          state <= S_ADD_WR;
        end

        // New entry goes at the fill count; an old tail, if any, gets linked next
        S_ADD_WR: begin
          list_valid[a_from] <= 1'b1;
          used               <= used + 1'b1;
          a_entry            <= e_now;
          link_at            <= tail_rd;
          if (list_valid[a_from]) begin
            state <= S_ADD_LINK;
          end else if (add_done) begin
            res_status <= gcdfs_pkg::ST_STORED;
            state      <= S_RESULT;
          end else begin
            a_from   <= a_to;
            a_to     <= a_from;
            a_second <= 1'b1;
            state    <= S_ADD_RD;
          end
        end

        S_ADD_LINK: begin
          if (add_done) begin
            res_status <= gcdfs_pkg::ST_STORED;
            state      <= S_RESULT;
          end else begin
            a_from   <= a_to;
            a_to     <= a_from;
            a_second <= 1'b1;
            state    <= S_ADD_RD;
          end
        end

        // Pick the next unvisited root, or report no cycle once all are scanned
        S_SCAN: begin
          if (scan_done) begin
            res_status <= gcdfs_pkg::ST_NO_CYCLE;
            state      <= S_RESULT;
          end else if (visited[scan_node]) begin
            scan_i <= scan_i + 1'b1;
          end else begin
            visited[scan_node] <= 1'b1;
            t_node             <= scan_node;
            t_par              <= gcdfs_pkg::NO_PARENT;
            sp                 <= '0;
            state              <= S_W_HEAD;
          end
        end

        S_W_HEAD: begin
          t_cur <= head_hit ? {1'b0, head_rd} : gcdfs_pkg::PTR_NIL;
          state <= S_W_EXAM;
        end

        S_W_EXAM: begin
          state <= t_cur[gcdfs_pkg::ENTRY_W] ? S_W_POP : S_W_EDGE;
        end

        // Neighbor in hand: descend, report, or move on
        S_W_EDGE: begin
          if (push) begin
            visited[tgt_rd] <= 1'b1;
            t_par           <= {1'b0, t_node};
            t_node          <= tgt_rd;
            sp              <= sp + 1'b1;
            state           <= S_W_HEAD;
          end else if (t_par != {1'b0, tgt_rd}) begin
            res_status <= gcdfs_pkg::ST_CYCLE;
            state      <= S_RESULT;
          end else begin
            t_cur <= nxt_rd;
            state <= S_W_EXAM;
          end
        end

        S_W_POP: begin
          if (sp == '0) begin
            scan_i <= scan_i + 1'b1;
            state  <= S_SCAN;
          end else begin
            sp    <= sp - 1'b1;
            state <= S_W_POPLD;
          end
        end

        S_W_POPLD: begin
          t_node <= stk_rd.node;
          t_cur  <= stk_rd.cur;
          t_par  <= stk_rd.par;
          state  <= S_W_EXAM;
        end

        // Hand the result to the output register once it is free
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `GCDFS_CHK_NOW(a_used_bound, 1'b1, 32'(used) <= gcdfs_pkg::MAX_ENTRIES, "fill count overflow")
  `GCDFS_CHK_NOW(a_top_visited, state == S_W_EXAM, visited[t_node], "walk top not marked visited")
  `GCDFS_CHK_NOW(a_stack_bound, state == S_W_EDGE, 32'(sp) < gcdfs_pkg::MAX_NODES, "stack overflow")
  `GCDFS_CHK_NEXT(a_clear_empties, in_valid && in_ready && in_item.action == gcdfs_pkg::ACT_CLEAR, used == '0 && list_valid == '0, "clear left entries")
  `GCDFS_CHK_NEXT(a_run_unmarks, in_valid && in_ready && in_item.action == gcdfs_pkg::ACT_RUN, visited == '0, "run did not clear visited marks")

endmodule

// ===== rtl/graph_cycle_detect_dfs.sv =====
// Cycle detector for a graph held as adjacency lists, walked depth first.
// Input stream (s_*): one command word per transfer. s_tuser carries the command
// (add edge, run check, clear graph); s_tdata carries the edge for an add.
// Output stream (m_*): one status word per command (edge stored, edge dropped,
// no cycle, cycle found, cleared); the unused command code gives no word.
// APB register 0 holds node_count, the number of walk roots (reset 64).
// Commands are handled one at a time: s_tready is high only while the sequencer
// is idle. Add edge does one RAM read of the list tail, then the entry write
// and, if the list already has entries, a tail link write, per stored direction;
// a dropped edge and clear go straight to the output word. Run scans up to
// node_count (at most 64) walk roots, with a head read per root and per node
// descended into, a read per list entry examined and a pop per frame; a cycle
// found ends it early. The walk steps through the single entry-pool read port.
// When m_tready is low the finished word waits in the output register; the
// block still takes the next command and holds its result until the register
// frees. Reset empties the graph, drops any pending word and sets node_count
// to 64; no memory clearing pass is needed.
module graph_cycle_detect_dfs (
  input  logic        clk,
  input  logic        rst,
  // Command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // node_from[5:0], node_to[11:6], directed[12], zero[15:13]
  input  logic [1:0]  s_tuser,   // action[1:0]
  // Status stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // status[2:0], zero[7:3]
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [gcdfs_pkg::NCNT_W-1:0] node_count;
  logic                         cfg_we;
  gcdfs_pkg::item_t             item;
  logic [gcdfs_pkg::STAT_W-1:0] status;

  // Register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && !paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= gcdfs_pkg::NCNT_W'(gcdfs_pkg::MAX_NODES);
    end else if (cfg_we) begin
      node_count <= pwdata[gcdfs_pkg::NCNT_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : 32'(node_count);

  // Word unpacking
  assign item.action    = s_tuser;
  assign item.node_from = s_tdata[5:0];
  assign item.node_to   = s_tdata[11:6];
  assign item.directed  = s_tdata[12];

  gcdfs_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (item),
    .node_count (node_count),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (status)
  );

  assign m_tdata = {5'b0, status};

endmodule
